### rtl/fnvc_pkg.sv
package fnvc_pkg;

  // Frame layout.
  localparam int unsigned HEADER_BYTES  = 12;
  localparam int unsigned PACKET_BYTES  = 16;
  localparam int unsigned TRAILER_BYTES = 4;
  localparam int unsigned MIN_FRAME     = HEADER_BYTES + TRAILER_BYTES;

  // Width that holds the expected frame length for any 32-bit command count.
  localparam int unsigned NEED_W = 32 + $clog2(PACKET_BYTES + 1) + 1;

  // FNV-1a 32-bit constants.
  localparam logic [31:0] HASH_BASIS = 32'd2166136261;
  localparam logic [31:0] HASH_PRIME = 32'd16777619;

  localparam logic [31:0] WANT_VERSION = 32'd1;
  localparam logic [31:0] COUNT_MAX    = 32'hFFFF_FFFF;

  // Header magic "IICL", entry 0 is the first byte on the wire.
  localparam logic [3:0][7:0] MAGIC_BYTES = {8'h4C, 8'h43, 8'h49, 8'h49};

  typedef enum logic [2:0] {
    STATUS_OK       = 3'd0,
    STATUS_SHORT    = 3'd1,
    STATUS_CHECKSUM = 3'd2,
    STATUS_MAGIC    = 3'd3,
    STATUS_VERSION  = 3'd4,
    STATUS_LENGTH   = 3'd5
  } status_e;

  // One input word as held in the input register.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_word_t;

  // Verdict given on the last byte of a frame.
  typedef struct packed {
    status_e     status;
    logic [31:0] command_count;
  } verdict_t;

endpackage

### rtl/fnvc_in_stage.sv
module fnvc_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fnvc_pkg::byte_word_t word_i,
  input  logic                out_free_i,
  output logic                fire_o,
  output fnvc_pkg::byte_word_t word_o
);
  import fnvc_pkg::*;

  logic       valid_q, valid_d;
  byte_word_t word_q;

  // A held word moves on when it gives no result or the result slot is free.
  assign fire_o     = valid_q && (!word_q.last || out_free_i);
  assign in_ready_o = !valid_q || fire_o;
  assign word_o     = word_q;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  // Valid flag of the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload of the input register.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      word_q <= word_i;
    end
  end

endmodule

### rtl/fnvc_frame.sv
module fnvc_frame (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  fnvc_pkg::byte_word_t word_i,
  output fnvc_pkg::verdict_t   verdict_o
);
  import fnvc_pkg::*;

  logic [31:0]      cnt_q, cnt_d;
  logic [31:0]      hash_q, hash_d, hash_mix, hash_mul;
  logic [3:0][7:0]  win_q, win_d;
  logic             magic_q, magic_d;
  logic [31:0]      version_q, version_d;
  logic [31:0]      hcount_q, hcount_d;
  logic [NEED_W-1:0] need;
  logic [NEED_W-1:0] payload;

  // Saturating byte count.
  assign cnt_d = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + 32'd1;

  // The hash takes in the byte that leaves the trailer window.
  assign hash_mix = hash_q ^ {24'b0, win_q[0]};
  assign hash_mul = hash_mix * HASH_PRIME;
  assign hash_d   = (cnt_q >= 32'(TRAILER_BYTES)) ? hash_mul : hash_q;

  // Window entry 0 is the oldest byte, so the window reads as the trailer.
  assign win_d = {word_i.data, win_q[3], win_q[2], win_q[1]};

  // Header parse: magic, then little-endian version and command count.
  always_comb begin
    magic_d   = magic_q;
    version_d = version_q;
    hcount_d  = hcount_q;
    if (cnt_q < 32'd4) begin
      if (word_i.data != MAGIC_BYTES[cnt_q[1:0]]) begin
        magic_d = 1'b0;
      end
    end else if (cnt_q < 32'd8) begin
      version_d = version_q | ({24'b0, word_i.data} << {cnt_q[1:0], 3'b000});
    end else if (cnt_q < 32'(HEADER_BYTES)) begin
      hcount_d = hcount_q | ({24'b0, word_i.data} << {cnt_q[1:0], 3'b000});
    end
  end

  // Expected and actual frame length without the trailer.
  assign need    = NEED_W'(HEADER_BYTES) + NEED_W'(hcount_d) * NEED_W'(PACKET_BYTES);
  assign payload = NEED_W'(cnt_d - 32'(TRAILER_BYTES));

  // Verdict, checks in priority order.
  always_comb begin
    verdict_o.command_count = 32'd0;
    if (cnt_d < 32'(MIN_FRAME)) begin
      verdict_o.status = STATUS_SHORT;
    end else if (hash_d != win_d) begin
      verdict_o.status = STATUS_CHECKSUM;
    end else if (!magic_d) begin
      verdict_o.status = STATUS_MAGIC;
    end else if (version_d != WANT_VERSION) begin
      verdict_o.status = STATUS_VERSION;
    end else if ((cnt_d == COUNT_MAX) || (payload != need)) begin
      verdict_o.status = STATUS_LENGTH;
    end else begin
      verdict_o.status        = STATUS_OK;
      verdict_o.command_count = hcount_d;
    end
  end

  // Frame state; a last byte returns it to the start of a new frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= 32'd0;
      hash_q    <= HASH_BASIS;
      win_q     <= '0;
      magic_q   <= 1'b1;
      version_q <= 32'd0;
      hcount_q  <= 32'd0;
    end else if (fire_i) begin
      if (word_i.last) begin
        cnt_q     <= 32'd0;
        hash_q    <= HASH_BASIS;
        win_q     <= '0;
        magic_q   <= 1'b1;
        version_q <= 32'd0;
        hcount_q  <= 32'd0;
      end else begin
        cnt_q     <= cnt_d;
        hash_q    <= hash_d;
        win_q     <= win_d;
        magic_q   <= magic_d;
        version_q <= version_d;
        hcount_q  <= hcount_d;
      end
    end
  end

endmodule

### rtl/framed_log_checker_fnv1a.sv
// A byte marked last is held in the input register; its verdict then loads into the result register.
// Throughput: one byte per cycle; a verdict held by the output side stalls nothing until
// the next last byte, which waits in the input register and holds back the bytes behind it.
// The path per byte is one 32-bit constant multiply of the hash and the checks.
// Reset (rst_ni low, asynchronous) empties both registers and starts a new frame.
module framed_log_checker_fnv1a (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [31:0] command_count_o
);
  import fnvc_pkg::*;

  byte_word_t in_word, held_word;
  verdict_t   verdict, verdict_q;
  logic       fire, out_free;
  logic       out_valid_q, out_valid_d;

  assign in_word.data = data_byte_i;
  assign in_word.last = last_byte_i;

  assign out_free = !out_valid_q || out_ready_i;

  fnvc_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .word_i     (in_word),
    .out_free_i (out_free),
    .fire_o     (fire),
    .word_o     (held_word)
  );

  fnvc_frame u_frame (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .word_i    (held_word),
    .verdict_o (verdict)
  );

  // Result register control.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = fire && held_word.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload loads with each verdict.
  always_ff @(posedge clk_i) begin
    if (fire && held_word.last) begin
      verdict_q <= verdict;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = verdict_q.status;
  assign command_count_o = verdict_q.command_count;

endmodule

### rtl/fnvc_checker.sv
module fnvc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        last_byte_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  status_o,
  input logic [31:0] command_count_o
);
  import fnvc_pkg::*;

  // A stalled verdict word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(command_count_o))
    else $error("verdict word changed while stalled");

  // Only defined status codes appear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= STATUS_LENGTH)
    else $error("undefined status code");

  // A failed frame reports no command count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STATUS_OK |-> command_count_o == 32'd0)
    else $error("command count given with a failing status");

  // A fresh verdict follows an accepted last byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && last_byte_i, 2))
    else $error("verdict without an accepted last byte");

endmodule

bind framed_log_checker_fnv1a fnvc_checker u_fnvc_checker (.*);

### verif/framed_log_checker_fnv1a_tb.sv
`timescale 1ns / 100ps

module framed_log_checker_fnv1a_tb;
  import fnvc_pkg::*;

  localparam int unsigned WORD_TARGET = 1450;
  localparam int unsigned FRAME_TARGET = 30;
  localparam int unsigned HOLD_CYCLES = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [31:0] command_count_o;

  framed_log_checker_fnv1a dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .command_count_o(command_count_o)
  );

  // Words waiting to be sent and verdicts waiting to arrive.
  byte_word_t  byte_q[$];
  verdict_t    verdict_q[$];
  int unsigned words_total = 0;
  int unsigned words_accepted = 0;
  int unsigned n_errors = 0;
  int unsigned cycle_n = 0;
  logic        hold_q = 1'b0;
  logic        calm;

  // Frame state of the predictor.
  logic [31:0]       frame_len;
  logic [31:0]       frame_hash;
  logic [3:0][7:0]   frame_tail;
  logic              magic_ok;
  logic [31:0]       hdr_version;
  logic [31:0]       hdr_count;

  // No random idling on either side inside this window.
  assign calm = (cycle_n >= 1800) && (cycle_n < 2800);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_n <= cycle_n + 1;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    n_errors++;
  endtask

  // One FNV-1a round over a single byte.
  function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
    return (h ^ {24'd0, b}) * HASH_PRIME;
  endfunction

  function automatic void clear_frame_state();
    frame_len   = '0;
    frame_hash  = HASH_BASIS;
    frame_tail  = '0;
    magic_ok    = 1'b1;
    hdr_version = '0;
    hdr_count   = '0;
  endfunction

  // Takes one word into the frame state; returns 1 with the verdict on a last word.
  function automatic bit absorb_byte(input logic [7:0] b, input logic last,
                                     output verdict_t v);
    logic [31:0] trailer;
    logic [63:0] need;
    logic [63:0] payload;
    if (frame_len >= 4) frame_hash = fnv_step(frame_hash, frame_tail[0]);
    frame_tail = {b, frame_tail[3:1]};
    if (frame_len < 4) begin
      if (b != MAGIC_BYTES[frame_len[1:0]]) magic_ok = 1'b0;
    end else if (frame_len < 8) begin
      hdr_version |= {24'd0, b} << (8 * (frame_len - 4));
    end else if (frame_len < HEADER_BYTES) begin
      hdr_count |= {24'd0, b} << (8 * (frame_len - 8));
    end
    if (frame_len != COUNT_MAX) frame_len++;
    v.status = STATUS_OK;
    v.command_count = '0;
    if (!last) return 1'b0;

    trailer = frame_tail;
    need = 64'(HEADER_BYTES) + 64'(hdr_count) * 64'(PACKET_BYTES);
    payload = 64'(frame_len) - 64'd4;
    if (frame_len < MIN_FRAME) v.status = STATUS_SHORT;
    else if (frame_hash != trailer) v.status = STATUS_CHECKSUM;
    else if (!magic_ok) v.status = STATUS_MAGIC;
    else if (hdr_version != WANT_VERSION) v.status = STATUS_VERSION;
    else if (frame_len == COUNT_MAX || payload != need) v.status = STATUS_LENGTH;
    else v.command_count = hdr_count;
    clear_frame_state();
    return 1'b1;
  endfunction

  task automatic push_bytes(ref logic [7:0] body[$]);
    byte_word_t w;
    foreach (body[i]) begin
      w.data = body[i];
      w.last = (i == body.size() - 1);
      byte_q = {byte_q, w};
    end
  endtask

  // Frame of random bytes of the given length.
  task automatic queue_random(input int unsigned len);
    logic [7:0] body[$];
    repeat (len) body = {body, 8'($urandom)};
    push_bytes(body);
  endtask

  // Well-formed frame with optional faults; header faults keep the trailer right.
  task automatic queue_frame(input int unsigned n_cmds, input bit bad_magic,
                             input bit bad_version, input bit bad_length,
                             input bit bad_sum);
    logic [7:0]  body[$];
    logic [31:0] ver;
    logic [31:0] cnt;
    logic [31:0] h;
    int unsigned pad;
    ver = WANT_VERSION;
    cnt = n_cmds;
    pad = 0;
    for (int i = 0; i < 4; i++) body = {body, MAGIC_BYTES[i]};
    if (bad_magic) body[$urandom_range(3)] ^= 8'($urandom_range(1, 255));
    if (bad_version) begin
      ver = ($urandom_range(1) == 0) ? $urandom : ver ^ (32'd1 << $urandom_range(31));
      if (ver == WANT_VERSION) ver = '0;
    end
    if (bad_length) begin
      if ($urandom_range(1) == 0) begin
        cnt = $urandom;
        if (cnt == n_cmds) cnt = cnt + 1;
      end else begin
        pad = $urandom_range(1, 2 * PACKET_BYTES);
      end
    end
    for (int i = 0; i < 4; i++) body = {body, ver[8*i +: 8]};
    for (int i = 0; i < 4; i++) body = {body, cnt[8*i +: 8]};
    repeat (n_cmds * PACKET_BYTES + pad) body = {body, 8'($urandom)};
    h = HASH_BASIS;
    foreach (body[i]) h = fnv_step(h, body[i]);
    if (bad_sum) h ^= 32'd1 << $urandom_range(31);
    for (int i = 0; i < 4; i++) body = {body, h[8*i +: 8]};
    push_bytes(body);
  endtask

  // Sender: keeps valid and the word steady until accepted, then offers the next.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      data_byte_i <= 8'h00;
      last_byte_i <= 1'b0;
    end else begin : send
      verdict_t   v;
      byte_word_t w;
      if (in_valid_i && in_ready_o) begin
        if (absorb_byte(data_byte_i, last_byte_i, v)) verdict_q = {verdict_q, v};
        words_accepted++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (byte_q.size() != 0 && (calm || $urandom_range(99) >= 17)) begin
          w = byte_q.pop_front();
          in_valid_i  <= 1'b1;
          data_byte_i <= w.data;
          last_byte_i <= w.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, none in the calm window, and a stall throughout the hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !hold_q && (calm || $urandom_range(99) >= 17);
    end
  end

  // Each verdict is compared with the oldest one predicted.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin : check
      verdict_t want;
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("verdict with none expected: status %0d count %0d",
                                  status_o, command_count_o));
      end else begin
        want = verdict_q.pop_front();
        if (status_o != want.status)
          report_mismatch($sformatf("status %0d, expected %0d", status_o, want.status));
        if (command_count_o != want.command_count)
          report_mismatch($sformatf("command count %0d, expected %0d",
                                    command_count_o, want.command_count));
      end
    end
  end

  // Long receiver hold-off while the sender keeps offering words.
  initial begin
    while (words_accepted < 300) @(posedge clk_i);
    hold_q <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_q <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("framed_log_checker_fnv1a_tb NOT OK");
    $finish;
  end

  initial begin : main
    int unsigned n_frames;
    int unsigned n_cmds;
    int unsigned pick;
    clear_frame_state();

    // Directed: one-byte frame, smallest good frame, wrong version.
    queue_random(1);
    queue_frame(0, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_frame(0, 1'b0, 1'b1, 1'b0, 1'b0);
    n_frames = 3;

    // Random: mostly well-formed frames, faults mixed so the check order is hit.
    while (byte_q.size() < WORD_TARGET || n_frames < FRAME_TARGET) begin
      pick = $urandom_range(99);
      n_cmds = ($urandom_range(9) == 0) ? $urandom_range(3, 6) : $urandom_range(0, 2);
      if (pick < 10) queue_random($urandom_range(1, MIN_FRAME - 1));
      else if (pick < 15) queue_random($urandom_range(MIN_FRAME, 60));
      else queue_frame(n_cmds, $urandom_range(99) < 15, $urandom_range(99) < 15,
                       $urandom_range(99) < 15, $urandom_range(99) < 15);
      n_frames++;
    end
    words_total = byte_q.size();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (words_accepted != words_total) @(posedge clk_i);
    for (int i = 0; i < 5000 && verdict_q.size() != 0; i++) @(posedge clk_i);
    if (verdict_q.size() != 0)
      report_mismatch($sformatf("%0d verdicts never arrived", verdict_q.size()));
    repeat (10) @(posedge clk_i);

    if (n_errors == 0) begin
      $display("framed_log_checker_fnv1a_tb OK");
    end else begin
      $display("framed_log_checker_fnv1a_tb NOT OK");
    end
    $finish;
  end

endmodule

### files.f
rtl/fnvc_pkg.sv
rtl/fnvc_in_stage.sv
rtl/fnvc_frame.sv
rtl/framed_log_checker_fnv1a.sv
rtl/fnvc_checker.sv
verif/framed_log_checker_fnv1a_tb.sv
